FILE: sv/abw_pkg.sv
package abw_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int CHANNELS_DEF   = 3;

    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int DIM_W    = 13;   // holds any image size up to 4096
    localparam int PROD_W   = 45;   // 32-bit coefficient times 13-bit position
    localparam int SUM_W    = 47;   // two products plus an offset
    localparam int FRAC_W   = 16;
    localparam int WGT_W    = 34;   // product of two 17-bit weights
    localparam int BLEND_W  = 42;   // 8-bit channel times a weight
    localparam int ACC_W    = 44;   // four blend terms
    localparam int QDEPTH   = 4;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_CC,
        REG_COEF_CR,
        REG_OFF_C,
        REG_COEF_RC,
        REG_COEF_RR,
        REG_OFF_R,
        REG_COLS,
        REG_ROWS
    } t_reg_idx;

    typedef struct packed {
        logic signed [CFG_W-1:0] coef_cc;
        logic signed [CFG_W-1:0] coef_cr;
        logic signed [CFG_W-1:0] off_c;
        logic signed [CFG_W-1:0] coef_rc;
        logic signed [CFG_W-1:0] coef_rr;
        logic signed [CFG_W-1:0] off_r;
        logic [9:0]              cols;
        logic [9:0]              rows;
    } t_cfg;

    typedef enum logic [1:0] {
        K_LOAD,
        K_HIT,
        K_MISS
    } t_kind;

    // px/py: column and row parity of the written pixel or of the top-left neighbor
    typedef struct packed {
        t_kind kind;
        logic  px;
        logic  py;
    } t_qctl;

    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [23:0]       pix;
    } t_qpay;

endpackage

FILE: sv/abw_in_if.sv
interface abw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [8:0]  load_col;
    logic [8:0]  load_row;
    logic [7:0]  load_ch0;
    logic [7:0]  load_ch1;
    logic [7:0]  load_ch2;
    logic [11:0] out_col;
    logic [11:0] out_row;

    modport source (
        output valid, mode, load_col, load_row, load_ch0, load_ch1, load_ch2,
               out_col, out_row,
        input  ready
    );
    modport sink (
        input  valid, mode, load_col, load_row, load_ch0, load_ch1, load_ch2,
               out_col, out_row,
        output ready
    );
endinterface

FILE: sv/abw_out_if.sv
interface abw_out_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [7:0] res_ch0;
    logic [7:0] res_ch1;
    logic [7:0] res_ch2;

    modport source (
        output valid, inside_res, res_ch0, res_ch1, res_ch2,
        input  ready
    );
    modport sink (
        input  valid, inside_res, res_ch0, res_ch1, res_ch2,
        output ready
    );
endinterface

FILE: sv/abw_ram.sv
module abw_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/abw_fifo.sv
module abw_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    import abw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    always_comb begin
        n_wptr  = i_push ? f_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop ? f_inc(r_rptr) : r_rptr;
        n_count = CW'(r_count + CW'(i_push) - CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == CW'(DEPTH)))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == CW'($past(r_count) + CW'($past(i_push))
                                          - CW'($past(i_pop))))
        else $error("queue occupancy out of step");
`endif
endmodule

FILE: sv/abw_front.sv
module abw_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int HW        = (MAX_WIDTH + 1) / 2,
    localparam int HH        = (MAX_HEIGHT + 1) / 2,
    localparam int DEPTH     = HW * HH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    abw_in_if.sink               i_pix,
    input  abw_pkg::t_cfg        i_cfg,
    output logic                 o_push,
    input  logic                 i_q_ready,
    output abw_pkg::t_qctl       o_ctl,
    output abw_pkg::t_qpay       o_pay,
    output logic [3:0][AW-1:0]   o_addr
);
    import abw_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic                     adv1, adv2;

    // stage 1: products
    logic                     r_v1;
    logic                     r_mode1;
    logic [8:0]               r_lcol1, r_lrow1;
    logic [23:0]              r_pix1;
    logic signed [PROD_W-1:0] r_pcc1, r_pcr1, r_prc1, r_prr1;
    logic signed [PROD_W-1:0] n_pcc, n_pcr, n_prc, n_prr;

    // stage 2: source point
    logic                     r_v2;
    logic                     r_mode2;
    logic [8:0]               r_lcol2, r_lrow2;
    logic [23:0]              r_pix2;
    logic signed [SUM_W-1:0]  r_pc2, r_pr2;

    // classification
    logic [DIM_W-1:0]         cols_eff, rows_eff;
    logic                     in_c, in_r, ld_ok, drop2;
    logic [XW-1:0]            ix;
    logic [YW-1:0]            iy;
    logic [XW-1:0]            colp [2];
    logic [YW-1:0]            rowp [2];

    always_comb begin
        n_pcc = i_cfg.coef_cc * $signed({1'b0, i_pix.out_col});
        n_pcr = i_cfg.coef_cr * $signed({1'b0, i_pix.out_row});
        n_prc = i_cfg.coef_rc * $signed({1'b0, i_pix.out_col});
        n_prr = i_cfg.coef_rr * $signed({1'b0, i_pix.out_row});
    end

    assign adv2        = !r_v2 || drop2 || i_q_ready;
    assign adv1        = !r_v1 || adv2;
    assign i_pix.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_pix.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_mode1 <= i_pix.mode;
            r_lcol1 <= i_pix.load_col;
            r_lrow1 <= i_pix.load_row;
            r_pix1  <= {i_pix.load_ch2, i_pix.load_ch1, i_pix.load_ch0};
            r_pcc1  <= n_pcc;
            r_pcr1  <= n_pcr;
            r_prc1  <= n_prc;
            r_prr1  <= n_prr;
        end
        if (adv2) begin
            r_mode2 <= r_mode1;
            r_lcol2 <= r_lcol1;
            r_lrow2 <= r_lrow1;
            r_pix2  <= r_pix1;
            r_pc2   <= SUM_W'(r_pcc1) + SUM_W'(r_pcr1) + SUM_W'(i_cfg.off_c);
            r_pr2   <= SUM_W'(r_prc1) + SUM_W'(r_prr1) + SUM_W'(i_cfg.off_r);
        end
    end

    // Clamp the size to the store, then test the interior [0, size-1).
    always_comb begin
        cols_eff = (DIM_W'(i_cfg.cols) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                           : DIM_W'(i_cfg.cols);
        rows_eff = (DIM_W'(i_cfg.rows) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                            : DIM_W'(i_cfg.rows);
        in_c = !r_pc2[SUM_W-1] && (cols_eff >= DIM_W'(2))
               && (r_pc2[SUM_W-2:FRAC_W] < (SUM_W-1-FRAC_W)'(cols_eff - DIM_W'(1)));
        in_r = !r_pr2[SUM_W-1] && (rows_eff >= DIM_W'(2))
               && (r_pr2[SUM_W-2:FRAC_W] < (SUM_W-1-FRAC_W)'(rows_eff - DIM_W'(1)));
        ld_ok = ({4'b0, r_lcol2} < DIM_W'(MAX_WIDTH))
                && ({4'b0, r_lrow2} < DIM_W'(MAX_HEIGHT));
        drop2 = r_v2 && !r_mode2 && !ld_ok;

        ix = r_pc2[FRAC_W +: XW];
        iy = r_pr2[FRAC_W +: YW];
        // even banks hold the neighbor after an odd index
        colp[0] = XW'((XW+1)'(ix) + (XW+1)'(1) >> 1);
        colp[1] = ix >> 1;
        rowp[0] = YW'((YW+1)'(iy) + (YW+1)'(1) >> 1);
        rowp[1] = iy >> 1;
    end

    always_comb begin
        o_push = r_v2 && !drop2 && i_q_ready;
        o_pay  = '{fx: r_pc2[FRAC_W-1:0], fy: r_pr2[FRAC_W-1:0], pix: r_pix2};
        if (!r_mode2) begin
            o_ctl     = '{kind: K_LOAD, px: r_lcol2[0], py: r_lrow2[0]};
            o_addr    = '0;
            o_addr[0] = AW'(AW'(r_lrow2 >> 1) * AW'(HW) + AW'(r_lcol2 >> 1));
        end else begin
            o_ctl = '{kind: (in_c && in_r) ? K_HIT : K_MISS, px: ix[0], py: iy[0]};
            for (int b = 0; b < 4; b++) begin
                o_addr[b] = AW'(AW'(rowp[b / 2]) * AW'(HW) + AW'(colp[b % 2]));
            end
        end
    end
endmodule

FILE: sv/abw_back.sv
module abw_back #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int CHANNELS   = 3,
    localparam int HW        = (MAX_WIDTH + 1) / 2,
    localparam int HH        = (MAX_HEIGHT + 1) / 2,
    localparam int DEPTH     = HW * HH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  abw_pkg::t_qctl       i_ctl,
    input  abw_pkg::t_qpay       i_pay,
    input  logic [3:0][AW-1:0]   i_addr,
    output logic                 o_pop,
    abw_out_if.source            o_res
);
    import abw_pkg::*;

    localparam int DW = 8 * CHANNELS;

    logic                           adv1, adv2, adv3;
    logic                           rd_en;
    logic [3:0]                     we;
    logic [3:0][DW-1:0]             rdata;
    logic [FRAC_W:0]                gx, gy, fx, fy;

    logic                           r_v1, r_hit1, r_px1, r_py1;
    logic [3:0][WGT_W-1:0]          r_w1;

    logic [3:0][DW-1:0]             nb;
    logic [CHANNELS-1:0][3:0][BLEND_W-1:0] n_prod, r_prod2;
    logic                           r_v2, r_hit2;

    logic                           r_v3, r_in3;
    logic [2:0][7:0]                n_ch, r_ch3;

    assign adv3  = !r_v3 || o_res.ready;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    // loads leave the queue at once; samples wait for a free first stage
    assign o_pop = i_q_valid && (i_ctl.kind == K_LOAD || adv1);
    assign rd_en = o_pop && i_ctl.kind == K_HIT;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        assign we[b] = o_pop && i_ctl.kind == K_LOAD && {i_ctl.py, i_ctl.px} == 2'(b);
        abw_ram #(.W(DW), .DEPTH(DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[b]),
            .i_waddr (i_addr[0]),
            .i_wdata (i_pay.pix[DW-1:0]),
            .i_re    (rd_en),
            .i_raddr (i_addr[b]),
            .o_rdata (rdata[b])
        );
    end

    always_comb begin
        fx = {1'b0, i_pay.fx};
        fy = {1'b0, i_pay.fy};
        gx = (FRAC_W+1)'(1 << FRAC_W) - fx;
        gy = (FRAC_W+1)'(1 << FRAC_W) - fy;
    end

    // Map banks back to neighbor order: top-left, top-right, bottom-left, bottom-right.
    always_comb begin
        nb[0] = rdata[{r_py1, r_px1}];
        nb[1] = rdata[{r_py1, !r_px1}];
        nb[2] = rdata[{!r_py1, r_px1}];
        nb[3] = rdata[{!r_py1, !r_px1}];
        for (int c = 0; c < CHANNELS; c++) begin
            for (int k = 0; k < 4; k++) begin
                n_prod[c][k] = BLEND_W'(nb[k][8*c +: 8]) * BLEND_W'(r_w1[k]);
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        if (c < CHANNELS) begin : g_used
            logic [ACC_W-1:0] acc;
            assign acc = ACC_W'(r_prod2[c][0]) + ACC_W'(r_prod2[c][1])
                       + ACC_W'(r_prod2[c][2]) + ACC_W'(r_prod2[c][3]);
            assign n_ch[c] = r_hit2 ? acc[39:32] : 8'd0;
        end else begin : g_unused
            assign n_ch[c] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= o_pop && i_ctl.kind != K_LOAD;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_hit1  <= i_ctl.kind == K_HIT;
            r_px1   <= i_ctl.px;
            r_py1   <= i_ctl.py;
            r_w1[0] <= WGT_W'(gx) * WGT_W'(gy);
            r_w1[1] <= WGT_W'(fx) * WGT_W'(gy);
            r_w1[2] <= WGT_W'(gx) * WGT_W'(fy);
            r_w1[3] <= WGT_W'(fx) * WGT_W'(fy);
        end
        if (adv2) begin
            r_hit2  <= r_hit1;
            r_prod2 <= n_prod;
        end
        if (adv3) begin
            r_in3 <= r_hit2;
            r_ch3 <= n_ch;
        end
    end

    assign o_res.valid      = r_v3;
    assign o_res.inside_res = r_in3;
    assign o_res.res_ch0    = r_ch3[0];
    assign o_res.res_ch1    = r_ch3[1];
    assign o_res.res_ch2    = r_ch3[2];

`ifndef SYNTHESIS
    a_port_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && (|we)))
        else $error("frame store read and written together");
    a_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !adv1) |-> !rd_en)
        else $error("read clobbers held neighbors");
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_in3) |-> (r_ch3 == '0))
        else $error("outside sample carries nonzero channels");
`endif
endmodule

FILE: sv/affine_bilinear_image_warp_top.sv
// Inverse-mapped affine warp with bilinear sampling.
//
// i_pix carries one beat per item. A load beat (mode 0) writes one source
// pixel into the frame store and yields no result. A sample beat (mode 1)
// names a destination pixel; it is mapped through the six Q16.16
// coefficients to a source point and yields exactly one o_res beat: the
// floored bilinear blend of the four neighbors and inside_res set, or zeros
// with inside_res clear when the point falls outside [0,cols-1)x[0,rows-1).
// Write the coefficients and sizes on i_cfg_* only while no beat is in flight.
//
// Throughput is one beat per cycle while o_res is ready. The frame store is
// four single-port-pair RAM banks split by column and row parity, so all four
// neighbors come out of a single read. The front (multiply, sum, classify)
// feeds a 4-entry queue; the back (bank access, weights, blend, output
// register) drains it. When o_res stalls the queue fills, then i_pix.ready
// drops. Reset restores the identity mapping and a 512x512 size; frame store
// contents stay undefined until loaded.
module affine_bilinear_image_warp_top #(
    parameter int MAX_WIDTH  = abw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = abw_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNELS   = abw_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [abw_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [abw_pkg::CFG_W-1:0]   i_cfg_data,
    abw_in_if.sink                      i_pix,
    abw_out_if.source                   o_res
);
    import abw_pkg::*;

    localparam int HW    = (MAX_WIDTH + 1) / 2;
    localparam int HH    = (MAX_HEIGHT + 1) / 2;
    localparam int DEPTH = HW * HH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = $bits(t_qctl) + $bits(t_qpay) + 4 * AW;

    t_cfg               r_cfg;

    logic               f_push, q_ready, q_valid, b_pop;
    t_qctl              f_ctl, q_ctl;
    t_qpay              f_pay, q_pay;
    logic [3:0][AW-1:0] f_addr, q_addr;
    logic [QW-1:0]      q_data;

    // Configuration registers: identity mapping over the full store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_cc <= CFG_W'(32'sd65536);
            r_cfg.coef_cr <= '0;
            r_cfg.off_c   <= '0;
            r_cfg.coef_rc <= '0;
            r_cfg.coef_rr <= CFG_W'(32'sd65536);
            r_cfg.off_r   <= '0;
            r_cfg.cols    <= 10'd512;
            r_cfg.rows    <= 10'd512;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_COEF_CC: r_cfg.coef_cc <= i_cfg_data;
                REG_COEF_CR: r_cfg.coef_cr <= i_cfg_data;
                REG_OFF_C:   r_cfg.off_c   <= i_cfg_data;
                REG_COEF_RC: r_cfg.coef_rc <= i_cfg_data;
                REG_COEF_RR: r_cfg.coef_rr <= i_cfg_data;
                REG_OFF_R:   r_cfg.off_r   <= i_cfg_data;
                REG_COLS:    r_cfg.cols    <= i_cfg_data[9:0];
                REG_ROWS:    r_cfg.rows    <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Front: map and classify each beat.
    abw_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (r_cfg),
        .o_push    (f_push),
        .i_q_ready (q_ready),
        .o_ctl     (f_ctl),
        .o_pay     (f_pay),
        .o_addr    (f_addr)
    );

    // Queue decouples front and back stalls.
    abw_fifo #(.W(QW), .DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_pay, f_addr}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (b_pop)
    );

    assign {q_ctl, q_pay, q_addr} = q_data;

    // Back: frame store access and blend.
    abw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_ctl     (q_ctl),
        .i_pay     (q_pay),
        .i_addr    (q_addr),
        .o_pop     (b_pop),
        .o_res     (o_res)
    );
endmodule

FILE: tb/sv/affine_bilinear_image_warp_top_tb.sv
module affine_bilinear_image_warp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import abw_pkg::*;

    localparam int STORE_W  = 512;
    localparam int STORE_H  = 512;
    // square patch of the frame store that is always loaded before sampling
    localparam int PATCH    = 20;
    localparam int RND_PHASES = 10;
    localparam int PHASE_BEATS = 66;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
    } t_pix_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    abw_in_if  pix_if ();
    abw_out_if res_if ();

    affine_bilinear_image_warp_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    // Shadow of the block: mapping registers, sizes and the source frame.
    int signed   m_cc, m_cr, m_oc, m_rc, m_rr, m_or;
    int unsigned m_cols, m_rows;
    bit [23:0]   frame_mem [STORE_W*STORE_H];
    bit          frame_loaded [STORE_W*STORE_H];

    t_pix_res    pending_pix[$];
    bit          no_idle;
    int          n_mismatch;
    int          n_loads, n_samples, n_inside, n_results;

    // 100 MHz clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Map a destination pixel to its Q16.16 source point; flag whether it is
    // strictly inside the sampling interior.
    function automatic bit map_point(input logic [11:0] dcol, input logic [11:0] drow,
                                     output longint pc, output longint pr);
        longint lim_c, lim_r;
        int unsigned c, r;
        pc = longint'(m_cc) * longint'(dcol) + longint'(m_cr) * longint'(drow)
             + longint'(m_oc);
        pr = longint'(m_rc) * longint'(dcol) + longint'(m_rr) * longint'(drow)
             + longint'(m_or);
        c = (m_cols > STORE_W) ? STORE_W : m_cols;
        r = (m_rows > STORE_H) ? STORE_H : m_rows;
        lim_c = (c < 2) ? 0 : longint'(c - 1) * 65536;
        lim_r = (r < 2) ? 0 : longint'(r - 1) * 65536;
        return !(pc < 0 || pr < 0 || pc >= lim_c || pr >= lim_r);
    endfunction

    // True when sampling this pixel touches only loaded frame entries.
    function automatic bit sample_safe(input logic [11:0] dcol, input logic [11:0] drow);
        longint pc, pr;
        int base;
        if (!map_point(dcol, drow, pc, pr))
            return 1'b1;
        base = int'(pr >>> 16) * STORE_W + int'(pc >>> 16);
        return frame_loaded[base] && frame_loaded[base + 1] &&
               frame_loaded[base + STORE_W] && frame_loaded[base + STORE_W + 1];
    endfunction

    function automatic t_pix_res bilinear_pixel(input logic [11:0] dcol,
                                                input logic [11:0] drow);
        t_pix_res res;
        longint pc, pr;
        longint unsigned fx, fy, gx, gy, acc;
        int base;
        bit [23:0] p00, p01, p10, p11;
        res = '0;
        if (!map_point(dcol, drow, pc, pr))
            return res;
        base = int'(pr >>> 16) * STORE_W + int'(pc >>> 16);
        fx = longint'(pc) & 64'hFFFF;
        fy = longint'(pr) & 64'hFFFF;
        gx = 65536 - fx;
        gy = 65536 - fy;
        p00 = frame_mem[base];
        p01 = frame_mem[base + 1];
        p10 = frame_mem[base + STORE_W];
        p11 = frame_mem[base + STORE_W + 1];
        res.hit = 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
            acc = longint'(p00[8*ch +: 8]) * gx * gy + longint'(p01[8*ch +: 8]) * fx * gy
                + longint'(p10[8*ch +: 8]) * gx * fy + longint'(p11[8*ch +: 8]) * fx * fy;
            case (ch)
                0: res.ch0 = acc[39:32];
                1: res.ch1 = acc[39:32];
                default: res.ch2 = acc[39:32];
            endcase
        end
        return res;
    endfunction

    // Drive one beat and hold it until accepted, then update the shadow.
    task automatic send_beat(input logic mode, input logic [8:0] lcol, input logic [8:0] lrow,
                             input logic [23:0] lpix, input logic [11:0] dcol,
                             input logic [11:0] drow);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 11) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.mode     <= mode;
        pix_if.load_col <= lcol;
        pix_if.load_row <= lrow;
        pix_if.load_ch0 <= lpix[7:0];
        pix_if.load_ch1 <= lpix[15:8];
        pix_if.load_ch2 <= lpix[23:16];
        pix_if.out_col  <= dcol;
        pix_if.out_row  <= drow;
        do @(posedge i_clk); while (!pix_if.ready);
        if (mode == 1'b0) begin
            frame_mem[int'(lrow) * STORE_W + int'(lcol)]    = lpix;
            frame_loaded[int'(lrow) * STORE_W + int'(lcol)] = 1'b1;
            n_loads++;
        end else begin
            pending_pix.push_back(bilinear_pixel(dcol, drow));
            n_samples++;
        end
    endtask

    task automatic load_pixel(input int col, input int row, input logic [23:0] pix);
        send_beat(1'b0, col[8:0], row[8:0], pix, 12'($urandom), 12'($urandom));
    endtask

    task automatic sample_pixel(input int col, input int row);
        send_beat(1'b1, 9'($urandom), 9'($urandom), 24'($urandom), col[11:0], row[11:0]);
    endtask

    // Drop valid, wait out every pending result plus pipeline latency.
    task automatic drain;
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        wait (pending_pix.size() == 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_COEF_CC: m_cc = int'(data);
            REG_COEF_CR: m_cr = int'(data);
            REG_OFF_C:   m_oc = int'(data);
            REG_COEF_RC: m_rc = int'(data);
            REG_COEF_RR: m_rr = int'(data);
            REG_OFF_R:   m_or = int'(data);
            REG_COLS:    m_cols = data[9:0];
            default:     m_rows = data[9:0];
        endcase
    endtask

    task automatic set_mapping(input int cc, input int cr, input int oc,
                               input int rc, input int rr, input int orow,
                               input int cols, input int rows);
        cfg_write(REG_COEF_CC, cc);
        cfg_write(REG_COEF_CR, cr);
        cfg_write(REG_OFF_C, oc);
        cfg_write(REG_COEF_RC, rc);
        cfg_write(REG_COEF_RR, rr);
        cfg_write(REG_OFF_R, orow);
        cfg_write(REG_COLS, cols);
        cfg_write(REG_ROWS, rows);
    endtask

    // Fill the patch with random pixels and hit the store corners and
    // all-zero / all-one channel values.
    task automatic test_load_patch;
        for (int r = 0; r < PATCH; r++)
            for (int c = 0; c < PATCH; c++)
                load_pixel(c, r, 24'($urandom));
        load_pixel(0, 0, 24'hFFFFFF);
        load_pixel(1, 0, 24'h000000);
        load_pixel(511, 511, 24'hFFFFFF);
        load_pixel(511, 0, 24'h000000);
        load_pixel(0, 511, 24'hA5A5A5);
    endtask

    // Directed samples under reset mapping, then the size and coefficient extremes.
    task automatic test_directed;
        sample_pixel(0, 0);
        sample_pixel(5, 7);
        sample_pixel(18, 18);
        sample_pixel(4095, 4095);
        sample_pixel(0, 4095);
        drain();
        // half-pixel column and three-quarter-pixel row shift inside a 20x20 image, then out past the right edge
        set_mapping(65536, 0, 32768, 0, 65536, 49152, PATCH, PATCH);
        sample_pixel(0, 0);
        sample_pixel(17, 3);
        sample_pixel(18, 18);
        sample_pixel(19, 0);
        drain();
        // negative offset pushes the origin outside
        set_mapping(65536, 0, -1, 0, 65536, 0, PATCH, PATCH);
        sample_pixel(0, 0);
        sample_pixel(1, 1);
        drain();
        // most positive and most negative coefficients
        set_mapping(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF,
                    32'h7FFFFFFF, PATCH, PATCH);
        sample_pixel(1, 1);
        sample_pixel(0, 0);
        sample_pixel(4095, 0);
        drain();
        set_mapping(0, 0, 32'h80000000, 0, 0, 32'h80000000, PATCH, PATCH);
        sample_pixel(3, 3);
        drain();
        // empty interior: one and zero columns
        set_mapping(65536, 0, 0, 0, 65536, 0, 1, PATCH);
        sample_pixel(0, 0);
        drain();
        cfg_write(REG_COLS, 0);
        cfg_write(REG_ROWS, 1);
        sample_pixel(0, 0);
        drain();
        // size above the store clamps to 512
        cfg_write(REG_COLS, 1023);
        cfg_write(REG_ROWS, 1023);
        sample_pixel(18, 18);
        sample_pixel(600, 5);
        sample_pixel(5, 600);
        drain();
    endtask

    // Random phases: fresh mapping each phase, mostly well-formed warps of
    // the patch with one wild coefficient set and noise loads.
    task automatic test_random;
        int cc, cr, oc, rc, rr, orow, cols, rows, dcol, drow;
        for (int ph = 0; ph < RND_PHASES; ph++) begin
            cols = $urandom_range(2, PATCH);
            rows = $urandom_range(2, PATCH);
            if (ph == 3) begin
                set_mapping($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            cols, rows);
            end else begin
                cc   = $urandom_range(0, 196608) - 98304;
                cr   = $urandom_range(0, 131072) - 65536;
                rc   = $urandom_range(0, 131072) - 65536;
                rr   = $urandom_range(0, 196608) - 98304;
                oc   = $urandom_range(0, cols * 65536);
                orow = $urandom_range(0, rows * 65536);
                set_mapping(cc, cr, oc, rc, rr, orow, cols, rows);
            end
            // one phase runs with neither side idling
            no_idle = (ph == 5);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // hold the stream once until every pending result is back
                if (ph == 6 && k == PHASE_BEATS / 2) begin
                    @(negedge i_clk);
                    pix_if.valid <= 1'b0;
                    wait (pending_pix.size() == 0);
                end
                if ($urandom_range(0, 99) < 20) begin
                    if ($urandom_range(0, 9) == 0)
                        load_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                                   24'($urandom));
                    else
                        load_pixel($urandom_range(0, PATCH - 1), $urandom_range(0, PATCH - 1),
                                   24'($urandom));
                end else begin
                    do begin
                        if ($urandom_range(0, 99) < 15) begin
                            dcol = $urandom_range(0, 4095);
                            drow = $urandom_range(0, 4095);
                        end else begin
                            dcol = $urandom_range(0, 24);
                            drow = $urandom_range(0, 24);
                        end
                    end while (!sample_safe(dcol[11:0], drow[11:0]));
                    sample_pixel(dcol, drow);
                end
            end
            no_idle = 1'b0;
            drain();
        end
    endtask

    // Result side: random back-pressure, compare each accepted beat in order.
    always @(negedge i_clk) begin
        if (i_rst_n)
            res_if.ready <= no_idle || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        t_pix_res want, got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.inside_res, res_if.res_ch0, res_if.res_ch1, res_if.res_ch2};
            n_results++;
            if (pending_pix.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: unexpected result beat %h", $realtime, got);
            end else begin
                want = pending_pix.pop_front();
                if (got.hit) n_inside++;
                if (got.hit !== want.hit || got.ch0 !== want.ch0 ||
                    got.ch1 !== want.ch1 || got.ch2 !== want.ch2) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: mismatch inside %b/%b ch0 %h/%h ch1 %h/%h ch2 %h/%h",
                                 $realtime, want.hit, got.hit, want.ch0, got.ch0,
                                 want.ch1, got.ch1, want.ch2, got.ch2);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_COEF_CC;
        i_cfg_data     = '0;
        pix_if.valid   = 1'b0;
        pix_if.mode    = 1'b0;
        pix_if.load_col = '0;
        pix_if.load_row = '0;
        pix_if.load_ch0 = '0;
        pix_if.load_ch1 = '0;
        pix_if.load_ch2 = '0;
        pix_if.out_col = '0;
        pix_if.out_row = '0;
        res_if.ready   = 1'b0;
        no_idle        = 1'b0;
        n_mismatch     = 0;
        n_loads        = 0;
        n_samples      = 0;
        n_inside       = 0;
        n_results      = 0;
        m_cc = 65536; m_cr = 0; m_oc = 0;
        m_rc = 0;     m_rr = 65536; m_or = 0;
        m_cols = 512; m_rows = 512;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_load_patch();
        test_directed();
        test_random();
        drain();

        // Non-empty queue here means a missing result.
        if (pending_pix.size() != 0) begin
            n_mismatch++;
            $display("%0d expected results never arrived", pending_pix.size());
        end
        $display("Covered %0d loads and %0d samples (%0d inside) over %0d mappings.",
                 n_loads, n_samples, n_inside, RND_PHASES + 7);
        $display("Mismatches: %0d in %0d result beats.", n_mismatch, n_results);
        if (n_mismatch == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: affine_bilinear_image_warp_top.f
sv/abw_pkg.sv
sv/abw_in_if.sv
sv/abw_out_if.sv
sv/abw_ram.sv
sv/abw_fifo.sv
sv/abw_front.sv
sv/abw_back.sv
sv/affine_bilinear_image_warp_top.sv
tb/sv/affine_bilinear_image_warp_top_tb.sv
